>>> rtl/core/union_find_slot_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// union_find_slot_allocator_top_defines.svh
// Assertion macros for the disjoint-set slot allocator. The macros use the
// clock and reset of the module that includes this file. Define NO_ASSERTIONS
// to leave every check out.
// ----------------------------------------------------------------------------
`ifndef UNION_FIND_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define UNION_FIND_SLOT_ALLOCATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define UFSA_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define UFSA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define UFSA_ASSERT(lbl, ante, cons, msg)
`define UFSA_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/core/ufsa_pkg.sv
// ----------------------------------------------------------------------------
// ufsa_pkg
// Shared types and constants of the disjoint-set slot allocator: channel
// payloads, controller states and the controller/datapath command bundles.
// ----------------------------------------------------------------------------
package ufsa_pkg;

   localparam int DEF_ELEMENTS = 1024;
   localparam int ITEM_W       = 10;
   localparam int COUNT_W      = 11;
   localparam int RANK_W       = 4;
   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(15);

   typedef struct packed {
      logic [ITEM_W-1:0] first_item;
      logic [ITEM_W-1:0] second_item;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic               merged;
      logic [ITEM_W-1:0]  set_root;
      logic [COUNT_W-1:0] members;
      logic [COUNT_W-1:0] free_slots;
      logic [COUNT_W-1:0] set_total;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK_ISSUE,
      ST_WALK_CHK,
      ST_COMP_ISSUE,
      ST_COMP_CHK,
      ST_RD_A,
      ST_RD_B,
      ST_LATCH_B,
      ST_UPDATE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clr_step;
      logic load_req;
      logic walk_issue;
      logic walk_chk;
      logic comp_issue;
      logic comp_chk;
      logic next_elem;
      logic rd_a;
      logic rd_b;
      logic latch_b;
      logic update;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last;
      logic hop_root;
      logic at_root;
      logic nx_root;
      logic sel_b;
      logic rsp_busy;
   } sts_type;

endpackage

>>> rtl/core/ufsa_ctrl.sv
// ----------------------------------------------------------------------------
// ufsa_ctrl
// Sequencer: clearing sweep after reset, root walk and path compression for
// each element, root data fetch and the final update.
// ----------------------------------------------------------------------------
module ufsa_ctrl import ufsa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_WALK_ISSUE;
            end
         end
         ST_WALK_ISSUE: begin
            cmd.walk_issue = 1'b1;
            state_in       = ST_WALK_CHK;
         end
         ST_WALK_CHK: begin
            cmd.walk_chk = 1'b1;
            if (sts.hop_root) begin
               state_in = ST_COMP_ISSUE;
            end
         end
         ST_COMP_ISSUE: begin
            priority if (!sts.at_root) begin
               cmd.comp_issue = 1'b1;
               state_in       = ST_COMP_CHK;
            end else if (sts.sel_b) begin
               state_in = ST_RD_A;
            end else begin
               cmd.next_elem = 1'b1;
               state_in      = ST_WALK_ISSUE;
            end
         end
         ST_COMP_CHK: begin
            cmd.comp_chk = 1'b1;
            priority if (!sts.nx_root) begin
               state_in = ST_COMP_CHK;
            end else if (sts.sel_b) begin
               state_in = ST_RD_A;
            end else begin
               cmd.next_elem = 1'b1;
               state_in      = ST_WALK_ISSUE;
            end
         end
         ST_RD_A: begin
            cmd.rd_a = 1'b1;
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            cmd.rd_b = 1'b1;
            state_in = ST_LATCH_B;
         end
         ST_LATCH_B: begin
            cmd.latch_b = 1'b1;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            // wait for the output register to drain
            if (!sts.rsp_busy) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

>>> rtl/core/ufsa_datapath.sv
// ----------------------------------------------------------------------------
// ufsa_datapath
// Parent, rank, size and free-count memories, walk registers, merge
// arithmetic, set counter and the result register.
// ----------------------------------------------------------------------------
`include "union_find_slot_allocator_top_defines.svh"

module ufsa_datapath import ufsa_pkg::*; #(
   parameter int ELEMENTS = DEF_ELEMENTS
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(ELEMENTS);
   localparam int CNT_W = $clog2(ELEMENTS + 1);
   localparam logic [31:0] LAST_IDX = 32'(ELEMENTS - 1);

   // storage
   logic [IDX_W-1:0]  parent_mem  [ELEMENTS];
   logic [RANK_W-1:0] rank_mem    [ELEMENTS];
   logic [CNT_W-1:0]  members_mem [ELEMENTS];
   logic [CNT_W-1:0]  free_mem    [ELEMENTS];

   logic [IDX_W-1:0]  parent_rd_ff;
   logic [RANK_W-1:0] rank_rd_ff;
   logic [CNT_W-1:0]  members_rd_ff;
   logic [CNT_W-1:0]  free_rd_ff;

   // registers
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [IDX_W-1:0]  a_ff, a_in;
   logic [IDX_W-1:0]  b_ff, b_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [IDX_W-1:0]  ra_ff, ra_in;
   logic [IDX_W-1:0]  rb_ff, rb_in;
   logic              sel_b_ff, sel_b_in;
   logic [RANK_W-1:0] rank_a_ff, rank_a_in;
   logic [RANK_W-1:0] rank_b_ff, rank_b_in;
   logic [CNT_W-1:0]  members_a_ff, members_a_in;
   logic [CNT_W-1:0]  members_b_ff, members_b_in;
   logic [CNT_W-1:0]  free_a_ff, free_a_in;
   logic [CNT_W-1:0]  free_b_ff, free_b_in;
   logic [CNT_W-1:0]  sets_ff, sets_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // combinational
   logic [IDX_W-1:0]  first_idx, second_idx;
   logic [IDX_W-1:0]  root_sel;
   logic              hop_root;
   logic              parent_re, parent_we;
   logic [IDX_W-1:0]  parent_ra, parent_wa, parent_wd;
   logic              info_re, rank_we, members_we, free_we;
   logic [IDX_W-1:0]  info_ra, info_wa;
   logic [RANK_W-1:0] rank_wd;
   logic [CNT_W-1:0]  members_wd, free_wd;

   logic              reject, same, swap, do_merge, do_same;
   logic [IDX_W-1:0]  hi_idx, lo_idx;
   logic [RANK_W-1:0] rank_hi, rank_lo, rank_new;
   logic [CNT_W-1:0]  mem_sum, free_sum, free_dec;
   logic [IDX_W-1:0]  res_root;
   logic [CNT_W-1:0]  res_mem, res_free;

   // out-of-range indices saturate to the last element
   assign first_idx  = (32'(req_data.first_item) > LAST_IDX) ?
                       IDX_W'(LAST_IDX) : IDX_W'(req_data.first_item);
   assign second_idx = (32'(req_data.second_item) > LAST_IDX) ?
                       IDX_W'(LAST_IDX) : IDX_W'(req_data.second_item);

   assign root_sel = sel_b_ff ? rb_ff : ra_ff;
   assign hop_root = (parent_rd_ff == cur_ff);

   assign sts.clr_last = (clr_ff == IDX_W'(LAST_IDX));
   assign sts.hop_root = hop_root;
   assign sts.at_root  = (cur_ff == root_sel);
   assign sts.nx_root  = (parent_rd_ff == root_sel);
   assign sts.sel_b    = sel_b_ff;
   assign sts.rsp_busy = rsp_valid_ff && rsp_stall;

   // merge decision on the two latched roots
   always_comb begin
      reject   = (free_a_ff == '0) && (free_b_ff == '0);
      same     = (ra_ff == rb_ff);
      swap     = (rank_a_ff > rank_b_ff);
      do_merge = !reject && !same;
      do_same  = !reject && same;
      hi_idx   = swap ? ra_ff : rb_ff;
      lo_idx   = swap ? rb_ff : ra_ff;
      rank_hi  = swap ? rank_a_ff : rank_b_ff;
      rank_lo  = swap ? rank_b_ff : rank_a_ff;
      rank_new = ((rank_hi == rank_lo) && (rank_hi != RANK_MAX)) ?
                 rank_hi + RANK_W'(1) : rank_hi;
      mem_sum  = CNT_W'({1'b0, members_a_ff} + {1'b0, members_b_ff});
      free_sum = CNT_W'({1'b0, free_a_ff} + {1'b0, free_b_ff} - (CNT_W + 1)'(1));
      free_dec = free_a_ff - CNT_W'(1);
      priority if (do_merge) begin
         res_root = hi_idx;
         res_mem  = mem_sum;
         res_free = free_sum;
      end else if (do_same) begin
         res_root = ra_ff;
         res_mem  = members_a_ff;
         res_free = free_dec;
      end else begin
         res_root = ra_ff;
         res_mem  = members_a_ff;
         res_free = free_a_ff;
      end
   end

   // memory port control
   always_comb begin
      parent_re = cmd.walk_issue || cmd.comp_issue || cmd.comp_chk ||
                  (cmd.walk_chk && !hop_root);
      parent_ra = (cmd.walk_chk || cmd.comp_chk) ? parent_rd_ff : cur_ff;
      parent_we = cmd.clr_step || cmd.comp_chk || (cmd.update && do_merge);
      priority if (cmd.clr_step) begin
         parent_wa = clr_ff;
         parent_wd = clr_ff;
      end else if (cmd.comp_chk) begin
         parent_wa = cur_ff;
         parent_wd = root_sel;
      end else begin
         parent_wa = lo_idx;
         parent_wd = hi_idx;
      end

      info_re    = cmd.rd_a || cmd.rd_b;
      info_ra    = cmd.rd_b ? rb_ff : ra_ff;
      // in a same-set claim hi_idx equals the shared root
      info_wa    = cmd.clr_step ? clr_ff : hi_idx;
      rank_we    = cmd.clr_step || (cmd.update && do_merge);
      members_we = rank_we;
      free_we    = cmd.clr_step || (cmd.update && !reject);
      rank_wd    = cmd.clr_step ? '0 : rank_new;
      members_wd = cmd.clr_step ? CNT_W'(1) : mem_sum;
      free_wd    = cmd.clr_step ? CNT_W'(1) : (same ? free_dec : free_sum);
   end

   always_ff @(posedge clock) begin
      if (parent_we) begin
         parent_mem[parent_wa] <= parent_wd;
      end
      if (parent_re) begin
         parent_rd_ff <= parent_mem[parent_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_mem[info_wa] <= rank_wd;
      end
      if (members_we) begin
         members_mem[info_wa] <= members_wd;
      end
      if (free_we) begin
         free_mem[info_wa] <= free_wd;
      end
      if (info_re) begin
         rank_rd_ff    <= rank_mem[info_ra];
         members_rd_ff <= members_mem[info_ra];
         free_rd_ff    <= free_mem[info_ra];
      end
   end

   // next-state of the working registers
   always_comb begin
      clr_in       = clr_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      cur_in       = cur_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      sel_b_in     = sel_b_ff;
      rank_a_in    = rank_a_ff;
      rank_b_in    = rank_b_ff;
      members_a_in = members_a_ff;
      members_b_in = members_b_ff;
      free_a_in    = free_a_ff;
      free_b_in    = free_b_ff;
      sets_in      = sets_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.clr_step) begin
         clr_in = clr_ff + IDX_W'(1);
      end
      if (cmd.load_req) begin
         a_in     = first_idx;
         b_in     = second_idx;
         cur_in   = first_idx;
         sel_b_in = 1'b0;
      end
      if (cmd.walk_chk) begin
         if (hop_root) begin
            if (sel_b_ff) begin
               rb_in = cur_ff;
            end else begin
               ra_in = cur_ff;
            end
            // restart from the element for the compression pass
            cur_in = sel_b_ff ? b_ff : a_ff;
         end else begin
            cur_in = parent_rd_ff;
         end
      end
      if (cmd.comp_chk) begin
         cur_in = parent_rd_ff;
      end
      if (cmd.next_elem) begin
         cur_in   = b_ff;
         sel_b_in = 1'b1;
      end
      if (cmd.rd_b) begin
         rank_a_in    = rank_rd_ff;
         members_a_in = members_rd_ff;
         free_a_in    = free_rd_ff;
      end
      if (cmd.latch_b) begin
         rank_b_in    = rank_rd_ff;
         members_b_in = members_rd_ff;
         free_b_in    = free_rd_ff;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.update) begin
         if (do_merge) begin
            sets_in = sets_ff - CNT_W'(1);
         end
         rsp_in.accepted   = !reject;
         rsp_in.merged     = do_merge;
         rsp_in.set_root   = ITEM_W'(res_root);
         rsp_in.members    = COUNT_W'(res_mem);
         rsp_in.free_slots = COUNT_W'(res_free);
         rsp_in.set_total  = COUNT_W'(sets_in);
         rsp_valid_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         sel_b_ff     <= 1'b0;
         sets_ff      <= CNT_W'(ELEMENTS);
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         sel_b_ff     <= sel_b_in;
         sets_ff      <= sets_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      cur_ff       <= cur_in;
      ra_ff        <= ra_in;
      rb_ff        <= rb_in;
      rank_a_ff    <= rank_a_in;
      rank_b_ff    <= rank_b_in;
      members_a_ff <= members_a_in;
      members_b_ff <= members_b_in;
      free_a_ff    <= free_a_in;
      free_b_ff    <= free_b_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `UFSA_ASSERT_NXT(a_merge_needs_claim, cmd.update, !rsp_ff.merged || rsp_ff.accepted, "merge reported on a rejected request")
   `UFSA_ASSERT(a_free_within_size, cmd.update, res_free <= res_mem, "free count exceeds set size")
   `UFSA_ASSERT_NXT(a_sets_fall, cmd.update && do_merge, sets_ff == $past(sets_ff) - CNT_W'(1), "set count did not fall on a merge")
   `UFSA_ASSERT(a_comp_off_root, cmd.comp_chk, cur_ff != root_sel, "compression write aimed at the root")

endmodule

>>> rtl/core/union_find_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// union_find_slot_allocator_top
// Disjoint-set slot allocator: union by rank with path compression, each set
// carrying a free slot count. One result per request.
//
//   channel  | ports                          | payload
//   ---------+--------------------------------+----------------------------
//   request  | req_valid, req_stall, req_data | first_item, second_item
//   result   | rsp_valid, rsp_stall, rsp_data | accepted .. set_total
//
// The time a request takes grows with da and db, the hop counts from each
// element to its root; union by rank keeps them near log2 ELEMENTS. The root
// walks use the single read port of the parent memory, one hop per cycle.
// After reset a clearing pass over every element initialises the memories;
// req_stall stays high meanwhile.
// A request is taken while an earlier result still waits in the output
// register; the final update waits only while that register is full and
// rsp_stall is high.
// ----------------------------------------------------------------------------
module union_find_slot_allocator_top import ufsa_pkg::*; #(
   parameter int ELEMENTS = DEF_ELEMENTS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   ufsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ufsa_datapath #(
      .ELEMENTS (ELEMENTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
